[hw/rtl/bpe_pkg.sv]
// bpe_pkg: shared types and constants for the bezier point evaluator
// used by the channel interfaces, the controller and the datapath
`timescale 1ns / 1ps

package bpe_pkg;

    localparam int KIND_W    = 1;
    localparam int IDX_IN_W  = 5;
    localparam int PIX_W     = 10;
    localparam int FRAC_W    = 8;
    localparam int COORD_W   = PIX_W + FRAC_W;
    localparam int T_W       = 17;
    localparam int CFG_CNT_W = 6;

    localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_EVAL  = 1'b1;

    // 1.0 in unsigned q1.16
    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_DRAIN,
        ST_FINISH
    } bpe_state_t;

    typedef struct packed {
        logic ctrl_wr;
        logic load_t;
        logic rd_en;
        logic rd_first;
        logic rd_ctrl;
        logic capture;
    } bpe_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_busy;
    } bpe_stat_t;

endpackage

[hw/rtl/bpe_in_if.sv]
// bpe_in_if: request channel, one beat is a point write or an evaluate
// depends on bpe_pkg for field widths
`timescale 1ns / 1ps

interface bpe_in_if;
    logic                          valid;
    logic                          ready;
    logic [bpe_pkg::KIND_W-1:0]    kind;
    logic [bpe_pkg::IDX_IN_W-1:0]  point_index;
    logic [bpe_pkg::PIX_W-1:0]     point_x;
    logic [bpe_pkg::PIX_W-1:0]     point_y;
    logic [bpe_pkg::T_W-1:0]       curve_t;

    modport source (output valid, kind, point_index, point_x, point_y, curve_t, input ready);
    modport sink (input valid, kind, point_index, point_x, point_y, curve_t, output ready);
endinterface

[hw/rtl/bpe_out_if.sv]
// bpe_out_if: result channel, one beat is one curve point
// depends on bpe_pkg for field widths
`timescale 1ns / 1ps

interface bpe_out_if;
    logic                          valid;
    logic                          ready;
    logic [bpe_pkg::COORD_W-1:0]   curve_x;
    logic [bpe_pkg::COORD_W-1:0]   curve_y;

    modport source (output valid, curve_x, curve_y, input ready);
    modport sink (input valid, curve_x, curve_y, output ready);
endinterface

[hw/rtl/bpe_datapath.sv]
// bpe_datapath: control point table, work point memory, shared lerp pipe and result register
// depends on bpe_pkg; driven by bpe_controller through bpe_cmd_t
`timescale 1ns / 1ps

module bpe_datapath #(
    parameter int MAX_POINTS = 32,
    parameter int IDX_W      = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bpe_pkg::bpe_cmd_t                 cmd,
    input  logic [IDX_W-1:0]                  rd_addr,
    output bpe_pkg::bpe_stat_t                stat,
    input  logic [bpe_pkg::IDX_IN_W-1:0]      point_index,
    input  logic [bpe_pkg::PIX_W-1:0]         point_x,
    input  logic [bpe_pkg::PIX_W-1:0]         point_y,
    input  logic [bpe_pkg::T_W-1:0]           curve_t,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [bpe_pkg::COORD_W-1:0]       curve_x,
    output logic [bpe_pkg::COORD_W-1:0]       curve_y
);

    localparam int CW = bpe_pkg::COORD_W;
    localparam int PW = bpe_pkg::PIX_W;

    logic [2*PW-1:0] ctrl_mem [0:MAX_POINTS-1];
    logic [2*CW-1:0] work_mem [0:MAX_POINTS-1];

    logic [2*PW-1:0]           ctrl_rdata_reg;
    logic [2*CW-1:0]           work_rdata_reg;
    logic [bpe_pkg::T_W-1:0]   t_reg;

    logic                      v1_reg;
    logic                      first1_reg;
    logic                      cap1_reg;
    logic                      src1_reg;
    logic [IDX_W-1:0]          addr1_reg;

    logic                      v2_reg;
    logic [IDX_W-1:0]          addr2_reg;
    logic [CW-1:0]             a_x_reg;
    logic [CW-1:0]             a_y_reg;
    logic [CW-1:0]             ahold_x_reg;
    logic [CW-1:0]             ahold_y_reg;
    logic [34:0]               prod_x_reg;
    logic [34:0]               prod_y_reg;

    logic                      out_valid_reg;
    logic [CW-1:0]             out_x_reg;
    logic [CW-1:0]             out_y_reg;

    logic [CW-1:0]             b_x;
    logic [CW-1:0]             b_y;
    logic signed [18:0]        d_x;
    logic signed [18:0]        d_y;
    logic signed [17:0]        t_s;
    logic signed [36:0]        px_full;
    logic signed [36:0]        py_full;
    logic [19:0]               sum_x;
    logic [19:0]               sum_y;

    // control points are whole pixels, widen to 1/256 pixel on the way out
    always_comb
    begin
        if (src1_reg)
        begin
            b_x = {ctrl_rdata_reg[2*PW-1:PW], {bpe_pkg::FRAC_W{1'b0}}};
            b_y = {ctrl_rdata_reg[PW-1:0], {bpe_pkg::FRAC_W{1'b0}}};
        end
        else
        begin
            b_x = work_rdata_reg[2*CW-1:CW];
            b_y = work_rdata_reg[CW-1:0];
        end
    end

    // a*(1-t)+b*t == a*2^16 + (b-a)*t, so one signed multiply per coordinate
    assign d_x     = $signed({1'b0, b_x}) - $signed({1'b0, a_x_reg});
    assign d_y     = $signed({1'b0, b_y}) - $signed({1'b0, a_y_reg});
    assign t_s     = $signed({1'b0, t_reg});
    assign px_full = d_x * t_s;
    assign py_full = d_y * t_s;

    // floor of product / 2^16 is the arithmetic shift, sign extended into the add
    assign sum_x = {2'b00, ahold_x_reg} + {prod_x_reg[34], prod_x_reg[34:16]};
    assign sum_y = {2'b00, ahold_y_reg} + {prod_y_reg[34], prod_y_reg[34:16]};

    always_ff @(posedge clk)
    begin
        if (cmd.ctrl_wr && (int'(point_index) < MAX_POINTS))
        begin
            ctrl_mem[IDX_W'(point_index)] <= {point_x, point_y};
        end
        if (cmd.rd_en)
        begin
            ctrl_rdata_reg <= ctrl_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            work_mem[addr2_reg] <= {sum_x[CW-1:0], sum_y[CW-1:0]};
        end
        if (cmd.rd_en)
        begin
            work_rdata_reg <= work_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_t)
        begin
            t_reg <= (curve_t > bpe_pkg::T_ONE) ? bpe_pkg::T_ONE : curve_t;
        end
        first1_reg <= cmd.rd_first;
        src1_reg   <= cmd.rd_ctrl;
        addr1_reg  <= rd_addr;
        if (v1_reg && !cap1_reg)
        begin
            a_x_reg <= b_x;
            a_y_reg <= b_y;
            if (!first1_reg)
            begin
                prod_x_reg  <= px_full[34:0];
                prod_y_reg  <= py_full[34:0];
                ahold_x_reg <= a_x_reg;
                ahold_y_reg <= a_y_reg;
                addr2_reg   <= addr1_reg - 1'b1;
            end
        end
        if (v1_reg && cap1_reg)
        begin
            out_x_reg <= b_x;
            out_y_reg <= b_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            cap1_reg      <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= cmd.rd_en;
            cap1_reg <= cmd.capture;
            v2_reg   <= v1_reg && !first1_reg && !cap1_reg;
            if (v1_reg && cap1_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.pipe_busy = v1_reg | v2_reg;
    assign stat.out_busy  = out_valid_reg;

    assign res_valid = out_valid_reg;
    assign curve_x   = out_x_reg;
    assign curve_y   = out_y_reg;

endmodule

[hw/rtl/bpe_controller.sv]
// bpe_controller: point count register and the sequencer over de casteljau levels
// depends on bpe_pkg; commands bpe_datapath through bpe_cmd_t
`timescale 1ns / 1ps

module bpe_controller #(
    parameter int MAX_POINTS = 32,
    parameter int IDX_W      = 5,
    parameter int CNT_W      = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bpe_pkg::CFG_CNT_W-1:0]     cfg_wr_data,
    input  logic                              req_valid,
    input  logic [bpe_pkg::KIND_W-1:0]        req_kind,
    output logic                              req_ready,
    input  bpe_pkg::bpe_stat_t                stat,
    output bpe_pkg::bpe_cmd_t                 cmd,
    output logic [IDX_W-1:0]                  rd_addr
);

    bpe_pkg::bpe_state_t              state_reg;
    bpe_pkg::bpe_state_t              state_next;
    logic [bpe_pkg::CFG_CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]                 level_reg;
    logic [CNT_W-1:0]                 level_next;
    logic [IDX_W-1:0]                 rd_idx_reg;
    logic [IDX_W-1:0]                 rd_idx_next;
    logic                             src_ctrl_reg;
    logic                             src_ctrl_next;

    logic [CNT_W-1:0]                 n_eff;
    logic [CNT_W-1:0]                 lvl_m1;

    always_comb
    begin
        if (count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (int'(count_reg) > MAX_POINTS)
        begin
            n_eff = CNT_W'(MAX_POINTS);
        end
        else
        begin
            n_eff = CNT_W'(count_reg);
        end
    end

    assign lvl_m1 = level_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bpe_pkg::ST_IDLE;
            count_reg    <= bpe_pkg::CFG_CNT_W'(1);
            level_reg    <= '0;
            rd_idx_reg   <= '0;
            src_ctrl_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            level_reg    <= level_next;
            rd_idx_reg   <= rd_idx_next;
            src_ctrl_reg <= src_ctrl_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        level_next    = level_reg;
        rd_idx_next   = rd_idx_reg;
        src_ctrl_next = src_ctrl_reg;
        cmd           = '0;
        rd_addr       = rd_idx_reg;
        req_ready     = 1'b0;
        unique case (state_reg)
            bpe_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_kind == bpe_pkg::KIND_WRITE)
                    begin
                        cmd.ctrl_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.load_t    = 1'b1;
                        level_next    = n_eff;
                        rd_idx_next   = '0;
                        src_ctrl_next = 1'b1;
                        // a single point skips straight to the result read
                        state_next = (n_eff == CNT_W'(1)) ? bpe_pkg::ST_FINISH
                                                          : bpe_pkg::ST_LEVEL;
                    end
                end
            end
            bpe_pkg::ST_LEVEL:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = (rd_idx_reg == '0);
                cmd.rd_ctrl  = src_ctrl_reg;
                if (rd_idx_reg == lvl_m1[IDX_W-1:0])
                begin
                    state_next = bpe_pkg::ST_DRAIN;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            bpe_pkg::ST_DRAIN:
            begin
                // next level reads what this one wrote, so let the lerp pipe empty
                if (!stat.pipe_busy)
                begin
                    level_next    = lvl_m1;
                    src_ctrl_next = 1'b0;
                    rd_idx_next   = '0;
                    state_next    = (lvl_m1 == CNT_W'(1)) ? bpe_pkg::ST_FINISH
                                                          : bpe_pkg::ST_LEVEL;
                end
            end
            bpe_pkg::ST_FINISH:
            begin
                rd_addr = '0;
                if (!stat.out_busy)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.capture = 1'b1;
                    cmd.rd_ctrl = src_ctrl_reg;
                    state_next  = bpe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/bezier_point_evaluator_core.sv]
// bezier_point_evaluator_core: a point write is stored in the cycle it is accepted; an evaluate over n points
// runs n-1 levels through the one shared lerp pipe (a single point goes straight to the result read):
// one read of the work memory per cycle, then a drain of the pipe at the end of each level
// one item at a time; the next request is taken while a result beat waits on the output
// rst_n is asynchronous active low: point count returns to 1, sequencer and output idle
// point tables are not cleared and must be written before they are used
`timescale 1ns / 1ps

module bezier_point_evaluator_core #(
    parameter int MAX_POINTS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bpe_pkg::CFG_CNT_W-1:0]     cfg_wr_data,
    bpe_in_if.sink                            request,
    bpe_out_if.source                         result
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    bpe_pkg::bpe_cmd_t   cmd;
    bpe_pkg::bpe_stat_t  stat;
    logic [IDX_W-1:0]    rd_addr;

    bpe_controller #(
        .MAX_POINTS (MAX_POINTS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (request.valid),
        .req_kind    (request.kind),
        .req_ready   (request.ready),
        .stat        (stat),
        .cmd         (cmd),
        .rd_addr     (rd_addr)
    );

    bpe_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .IDX_W      (IDX_W)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .stat        (stat),
        .point_index (request.point_index),
        .point_x     (request.point_x),
        .point_y     (request.point_y),
        .curve_t     (request.curve_t),
        .res_valid   (result.valid),
        .res_ready   (result.ready),
        .curve_x     (result.curve_x),
        .curve_y     (result.curve_y)
    );

endmodule

[tb/bpe_result_checker.sv]
// bpe_result_checker: watches the config port and both channels of the bezier point evaluator,
// predicts every curve point by de casteljau reduction and compares it with the result beat
// depends on bpe_pkg and the bpe_in_if / bpe_out_if channel interfaces
`timescale 1ns / 1ps

module bpe_result_checker #(
    parameter int MAX_POINTS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bpe_pkg::CFG_CNT_W-1:0] cfg_wr_data,
    input  logic                          run_done,
    bpe_in_if                             req_mon,
    bpe_out_if                            res_mon,
    output int                            pending,
    output int                            mismatches
);
    import bpe_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } curve_pt_t;

    logic [PIX_W-1:0]     ctrl_x [MAX_POINTS];
    logic [PIX_W-1:0]     ctrl_y [MAX_POINTS];
    logic [CFG_CNT_W-1:0] pt_count;
    curve_pt_t            curve_q [$];
    bit                   done_seen;
    int                   beat_no;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] curve mismatch: %s", $time, what);
    endtask

    // one interpolation step, 64-bit sum then truncate
    function automatic logic [COORD_W-1:0] blend(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b,
                                                 input logic [T_W-1:0] t);
        longint unsigned la;
        longint unsigned lb;
        longint unsigned lt;
        longint unsigned acc;
        la  = a;
        lb  = b;
        lt  = t;
        acc = la * (64'd65536 - lt) + lb * lt;
        return acc[16 +: COORD_W];
    endfunction

    function automatic curve_pt_t predict_point(input logic [T_W-1:0] t_in);
        logic [COORD_W-1:0] wx [MAX_POINTS];
        logic [COORD_W-1:0] wy [MAX_POINTS];
        logic [T_W-1:0]     t_use;
        int                 n;
        curve_pt_t          pt;
        t_use = (t_in > T_ONE) ? T_ONE : t_in;
        n = (pt_count == 0) ? 1 : int'(pt_count);
        if (n > MAX_POINTS)
            n = MAX_POINTS;
        for (int i = 0; i < n; i++)
        begin
            wx[i] = {ctrl_x[i], {FRAC_W{1'b0}}};
            wy[i] = {ctrl_y[i], {FRAC_W{1'b0}}};
        end
        // each level shrinks the working set by one point
        for (int lvl = n; lvl > 1; lvl--)
        begin
            for (int i = 0; i + 1 < lvl; i++)
            begin
                wx[i] = blend(wx[i], wx[i + 1], t_use);
                wy[i] = blend(wy[i], wy[i + 1], t_use);
            end
        end
        pt.x = wx[0];
        pt.y = wy[0];
        return pt;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        curve_pt_t got;
        curve_pt_t want;
        if (!rst_n)
        begin
            pt_count   = 1;
            curve_q.delete();
            done_seen  = 1'b0;
            beat_no    = 0;
            mismatches = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                pt_count = cfg_wr_data;

            if (res_mon.valid && res_mon.ready)
            begin
                got.x = res_mon.curve_x;
                got.y = res_mon.curve_y;
                beat_no++;
                if (curve_q.size() == 0)
                    report_mismatch($sformatf("beat %0d with no evaluate outstanding (x=%0d y=%0d)",
                                              beat_no, got.x, got.y));
                else
                begin
                    want = curve_q.pop_front();
                    if (got.x !== want.x)
                        report_mismatch($sformatf("beat %0d curve_x got %0d want %0d",
                                                  beat_no, got.x, want.x));
                    if (got.y !== want.y)
                        report_mismatch($sformatf("beat %0d curve_y got %0d want %0d",
                                                  beat_no, got.y, want.y));
                end
            end

            if (req_mon.valid && req_mon.ready)
            begin
                if (req_mon.kind == KIND_WRITE)
                begin
                    if (req_mon.point_index < MAX_POINTS)
                    begin
                        ctrl_x[req_mon.point_index] = req_mon.point_x;
                        ctrl_y[req_mon.point_index] = req_mon.point_y;
                    end
                end
                else
                    curve_q.push_back(predict_point(req_mon.curve_t));
            end

            if (run_done && !done_seen)
            begin
                done_seen = 1'b1;
                if (curve_q.size() != 0)
                    report_mismatch($sformatf("%0d curve points never came out", curve_q.size()));
            end

            pending <= curve_q.size();
        end
    end

endmodule

[tb/tb_top.sv]
// tb_top: drives point writes, evaluates and point_count settings into the bezier point
// evaluator with random idling on both channels; depends on bpe_pkg, the channel interfaces,
// bezier_point_evaluator_core and bpe_result_checker, which does all the checking
`timescale 1ns / 1ps

module tb_top;
    import bpe_pkg::*;

    localparam int              TABLE_DEPTH  = 32;
    localparam longint unsigned RUN_LIMIT_NS = 64'd20_000_000;
    localparam int              END_WAIT     = 5000;
    localparam int              DRAIN_CYCLES = 700;
    localparam int              IDLE_PCT     = 21;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_CNT_W-1:0]   cfg_wr_data;
    logic                   run_done;
    logic                   calm;
    int                     pending;
    int                     mismatches;

    logic [TABLE_DEPTH-1:0] written;
    logic [CFG_CNT_W-1:0]   cur_count;
    logic [CFG_CNT_W-1:0]   phase_counts [12];
    int                     n_writes;
    int                     n_evals;
    int                     n_settings;

    bpe_in_if  request_ch ();
    bpe_out_if result_ch ();

    bezier_point_evaluator_core #(
        .MAX_POINTS (TABLE_DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .request     (request_ch),
        .result      (result_ch)
    );

    bpe_result_checker #(
        .MAX_POINTS (TABLE_DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .run_done    (run_done),
        .req_mon     (request_ch),
        .res_mon     (result_ch),
        .pending     (pending),
        .mismatches  (mismatches)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
        result_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    function automatic int used_points(input logic [CFG_CNT_W-1:0] c);
        if (c == 0)
            return 1;
        if (c > TABLE_DEPTH)
            return TABLE_DEPTH;
        return int'(c);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pix();
        return PIX_W'($urandom);
    endfunction

    function automatic logic [T_W-1:0] rand_t();
        return T_W'($urandom);
    endfunction

    task automatic send_request(input logic [KIND_W-1:0]   kind,
                                input logic [IDX_IN_W-1:0] idx,
                                input logic [PIX_W-1:0]    px,
                                input logic [PIX_W-1:0]    py,
                                input logic [T_W-1:0]      t);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            request_ch.valid <= 1'b0;
            @(posedge clk);
        end
        request_ch.valid       <= 1'b1;
        request_ch.kind        <= kind;
        request_ch.point_index <= idx;
        request_ch.point_x     <= px;
        request_ch.point_y     <= py;
        request_ch.curve_t     <= t;
        @(posedge clk);
        while (request_ch.ready !== 1'b1)
            @(posedge clk);
        if (kind == KIND_WRITE)
        begin
            written[idx] = 1'b1;
            n_writes++;
        end
        else
            n_evals++;
    endtask

    // an evaluate may only read written slots, so fill the lowest hole first
    task automatic issue_eval(input logic [T_W-1:0] t);
        int gap_slot;
        gap_slot = -1;
        for (int i = used_points(cur_count) - 1; i >= 0; i--)
            if (!written[i])
                gap_slot = i;
        if (gap_slot >= 0)
            send_request(KIND_WRITE, IDX_IN_W'(gap_slot), rand_pix(), rand_pix(), rand_t());
        else
            send_request(KIND_EVAL, IDX_IN_W'($urandom), rand_pix(), rand_pix(), t);
    endtask

    task automatic wait_idle();
        request_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // a point write accepted after the last result may still be in flight
        repeat (8) @(posedge clk);
    endtask

    task automatic set_point_count(input logic [CFG_CNT_W-1:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_count    = v;
        n_settings++;
    endtask

    task automatic random_request();
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic [T_W-1:0]   t;
        if ($urandom_range(0, 99) < 35)
        begin
            px = rand_pix();
            py = rand_pix();
            case ($urandom_range(0, 7))
                0: px = '0;
                1: px = '1;
                2: py = '0;
                3: py = '1;
                default: ;
            endcase
            send_request(KIND_WRITE, IDX_IN_W'($urandom), px, py, rand_t());
        end
        else
        begin
            case ($urandom_range(0, 9))
                0: t = '0;
                1: t = T_ONE;
                2: t = T_W'($urandom_range(65537, 131071));
                default: t = T_W'($urandom_range(0, 65536));
            endcase
            issue_eval(t);
        end
    endtask

    initial
    begin
        int phase_items;
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        run_done               = 1'b0;
        calm                   = 1'b0;
        written                = '0;
        cur_count              = 1;
        n_writes               = 0;
        n_evals                = 0;
        n_settings             = 0;
        request_ch.valid       = 1'b0;
        request_ch.kind        = KIND_WRITE;
        request_ch.point_index = '0;
        request_ch.point_x     = '0;
        request_ch.point_y     = '0;
        request_ch.curve_t     = '0;
        result_ch.ready        = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single point at reset count: full-scale corner, t at zero, one and past one
        send_request(KIND_WRITE, '0, '1, '1, rand_t());
        issue_eval('0);
        issue_eval(T_ONE);
        issue_eval('1);
        send_request(KIND_WRITE, '0, '0, '0, rand_t());
        issue_eval(T_W'(40000));
        send_request(KIND_WRITE, IDX_IN_W'(1), '1, '0, rand_t());
        send_request(KIND_WRITE, IDX_IN_W'(2), '0, '1, rand_t());

        // straight line between two adjacent corners
        set_point_count(2);
        issue_eval('0);
        issue_eval(T_ONE);
        issue_eval(T_W'(32768));
        issue_eval(T_W'(1));
        issue_eval(T_W'(65535));

        set_point_count(3);
        issue_eval(T_W'(32768));
        issue_eval(T_W'(100000));

        // zero count behaves as one point
        set_point_count(0);
        send_request(KIND_WRITE, '0, PIX_W'(512), PIX_W'(1), rand_t());
        issue_eval(rand_t());
        send_request(KIND_WRITE, IDX_IN_W'(31), '1, '1, rand_t());
        issue_eval(T_ONE);

        phase_counts = '{6'd4, 6'd2, 6'd32, 6'd7, 6'd1, 6'd63,
                         6'd3, 6'd0, 6'd12, 6'd5, 6'd45, 6'd9};
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 8)
                phase_counts[ph] = CFG_CNT_W'($urandom_range(8, 20));
            set_point_count(phase_counts[ph]);
            calm <= (ph == 3);
            // full-table evaluations are slow, keep those phases short
            phase_items = (used_points(phase_counts[ph]) == TABLE_DEPTH) ? 40 : 120;
            repeat (phase_items) random_request();
        end

        request_ch.valid <= 1'b0;
        @(posedge clk);
        for (int c = 0; c < END_WAIT && pending != 0; c++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        run_done <= 1'b1;
        repeat (2) @(posedge clk);

        $display("covered %0d point writes and %0d evaluates over %0d point_count settings",
                 n_writes, n_evals, n_settings);
        $display("counts included 0, 1, 2, the full table and values past it; t from 0 past 1.0");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("run timed out with %0d curve points outstanding", pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[bezier_point_evaluator_core.f]
hw/rtl/bpe_pkg.sv
hw/rtl/bpe_in_if.sv
hw/rtl/bpe_out_if.sv
hw/rtl/bpe_datapath.sv
hw/rtl/bpe_controller.sv
hw/rtl/bezier_point_evaluator_core.sv
tb/bpe_result_checker.sv
tb/tb_top.sv
